[design/slst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_pkg
// Shared types and constants for the solenoid latch and stepper tracker.
// ----------------------------------------------------------------------------
package slst_pkg;

    localparam logic [1:0] OFF_FLIP  = 2'd0;
    localparam logic [1:0] OFF_LOW   = 2'd1;
    localparam logic [1:0] OFF_MID   = 2'd2;
    localparam logic [1:0] OFF_MOTOR = 2'd3;

    localparam logic [3:0] PH_A    = 4'hc;
    localparam logic [3:0] PH_B    = 4'h6;
    localparam logic [3:0] PH_C    = 4'h3;
    localparam logic [3:0] PH_D    = 4'h9;
    localparam logic [3:0] PH_NONE = 4'h0;

    typedef logic signed [1:0] t_dir;

    localparam t_dir DIR_STOP = 2'sd0;
    localparam t_dir DIR_FWD  = 2'sd1;
    localparam t_dir DIR_REV  = -2'sd1;

    typedef struct packed {
        logic       en;
        logic [3:0] phase;
    } t_step_cmd;

    function automatic logic [3:0] next_phase(input logic [3:0] p);
        logic [3:0] r;
        case (p)
            PH_A:    r = PH_B;
            PH_B:    r = PH_C;
            PH_C:    r = PH_D;
            PH_D:    r = PH_A;
            default: r = PH_NONE;
        endcase
        return r;
    endfunction

endpackage

[design/slst_step_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_step_tracker
// Full-step phase decoder with saturating position count and direction.
// ----------------------------------------------------------------------------
module slst_step_tracker #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  slst_pkg::t_step_cmd      i_cmd,
    output logic [POSITION_BITS-1:0] o_next_count,
    output slst_pkg::t_dir           o_next_dir
);
    import slst_pkg::*;

    logic [3:0]               r_last;
    logic [3:0]               n_last;
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;
    t_dir                     r_dir;
    t_dir                     n_dir;
    logic                     fwd;
    logic                     rev;

    always_comb begin
        fwd     = (r_last != PH_NONE) && (next_phase(r_last) == i_cmd.phase);
        rev     = (next_phase(i_cmd.phase) != PH_NONE) &&
                  (next_phase(i_cmd.phase) == r_last);
        n_last  = r_last;
        n_count = r_count;
        n_dir   = r_dir;
        if (i_cmd.en) begin
            if (i_cmd.phase == PH_NONE) begin
                n_dir = DIR_STOP;
            end else if (i_cmd.phase != r_last) begin
                if (fwd) begin
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                    n_dir = DIR_FWD;
                end else if (rev) begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_dir = DIR_REV;
                end
                n_last = i_cmd.phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= PH_NONE;
            r_count <= '0;
            r_dir   <= DIR_STOP;
        end else begin
            r_last  <= n_last;
            r_count <= n_count;
            r_dir   <= n_dir;
        end
    end

    assign o_next_count = n_count;
    assign o_next_dir   = n_dir;

endmodule

[design/solenoid_latch_stepper_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solenoid_latch_stepper_tracker
// Byte-lane solenoid latch with flipper extraction and stepper phase tracking.
//
//  channel  handshake                 payload
//  in       i_in_valid / o_in_stall   i_reg_offset, i_write_byte
//  out      o_out_valid / i_out_stall pulsed word, flipper, motor, actuators
//
// One write per cycle while the result is not stalled; the result appears in the cycle after its transfer.
// The latency is set by the single result register.
// Synchronous active-low reset clears the latch, the tracker and out valid.
// A stalled result holds the input off until it is taken.
// ----------------------------------------------------------------------------
module solenoid_latch_stepper_tracker #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_reg_offset,
    input  logic [7:0]           i_write_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_pulsed_word,
    output logic [2:0]           o_flipper_pulse,
    output slst_pkg::t_dir       o_motor_direction,
    output logic                 o_arms_up,
    output logic                 o_legs_up,
    output logic [15:0]          o_motor_position,
    output logic                 o_at_home
);
    import slst_pkg::*;

    localparam int SHOW_BITS = (POSITION_BITS < 16) ? POSITION_BITS : 16;

    logic                     accept;
    logic [31:0]              r_word;
    logic [31:0]              n_word;
    logic [2:0]               n_flip;
    logic                     r_arms;
    logic                     n_arms;
    logic                     r_legs;
    logic                     n_legs;
    t_step_cmd                cmd;
    logic [POSITION_BITS-1:0] next_count;
    t_dir                     next_dir;

    logic                     r_out_valid;
    logic [31:0]              r_out_word;
    logic [2:0]               r_out_flip;
    t_dir                     r_out_dir;
    logic                     r_out_arms;
    logic                     r_out_legs;
    logic [15:0]              r_out_pos;
    logic                     r_out_home;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_word = r_word;
        n_flip = 3'b000;
        n_arms = r_arms;
        n_legs = r_legs;
        unique case (i_reg_offset)
            OFF_FLIP: begin
                n_word[15:8] = {2'b00, i_write_byte[5:0]};
                n_flip       = {i_write_byte[6], 1'b0, i_write_byte[7]};
            end
            OFF_LOW: begin
                n_word[7:0] = i_write_byte;
            end
            OFF_MID: begin
                n_word[23:16] = i_write_byte;
            end
            OFF_MOTOR: begin
                n_word[31:24] = i_write_byte;
                n_legs        = i_write_byte[4];
                n_arms        = i_write_byte[5];
            end
            default: begin
                n_word = r_word;
            end
        endcase
        cmd.en    = accept && (i_reg_offset == OFF_MOTOR);
        cmd.phase = i_write_byte[3:0];
    end

    slst_step_tracker #(
        .POSITION_BITS(POSITION_BITS)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_next_count(next_count),
        .o_next_dir  (next_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_arms      <= 1'b0;
            r_legs      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_word <= n_word;
                r_arms <= n_arms;
                r_legs <= n_legs;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_word;
            r_out_flip <= n_flip;
            r_out_dir  <= next_dir;
            r_out_arms <= n_arms;
            r_out_legs <= n_legs;
            r_out_pos  <= 16'(next_count[SHOW_BITS-1:0]);
            r_out_home <= (next_count == '0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pulsed_word     = r_out_word;
    assign o_flipper_pulse   = r_out_flip;
    assign o_motor_direction = r_out_dir;
    assign o_arms_up         = r_out_arms;
    assign o_legs_up         = r_out_legs;
    assign o_motor_position  = r_out_pos;
    assign o_at_home         = r_out_home;

endmodule

[design/slst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_checker
// Port-level checks on the result channel of the solenoid latch tracker.
// ----------------------------------------------------------------------------
module slst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_pulsed_word,
    input logic [2:0]  o_flipper_pulse,
    input logic [1:0]  o_motor_direction,
    input logic [15:0] o_motor_position,
    input logic        o_at_home
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pulsed_word) &&
        $stable(o_motor_position) && $stable(o_motor_direction))
        else $error("stalled result changed");

    a_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_at_home |-> o_motor_position == 16'd0)
        else $error("home set with nonzero position");

    a_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_flipper_pulse[1])
        else $error("flipper middle bit set");

    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pulsed_word[15:14] == 2'b00)
        else $error("masked solenoid bits set");

    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_motor_direction != 2'b10)
        else $error("illegal direction code");

endmodule

bind solenoid_latch_stepper_tracker slst_checker u_slst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_pulsed_word    (o_pulsed_word),
    .o_flipper_pulse  (o_flipper_pulse),
    .o_motor_direction(o_motor_direction),
    .o_motor_position (o_motor_position),
    .o_at_home        (o_at_home)
);
